// ===== src/lcio_pkg.sv =====
// Shared types, constants and reply text tables for the line command I/O controller.
package lcio_pkg;

   localparam int NUM_PINS     = 4;
   localparam int PREFIX_DEPTH = 7;
   localparam int PFX_IDX_W    = 3;
   localparam int ID_LEN       = 17;
   localparam int IDX_W        = 5;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = 2;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_V     = 8'h56;
   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_R     = 8'h52;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_QUERY = 8'h3F;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;

   localparam logic [7:0] THRESHOLD_RESET = 8'd10;

   // Reply kinds carried from front to back
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_IDENT  = 2'd1;
   localparam logic [1:0] KIND_RELAY  = 2'd2;
   localparam logic [1:0] KIND_STATUS = 2'd3;

   localparam logic [7:0] ID_TEXT [ID_LEN] = '{
      8'h54, 8'h6F, 8'h72, 8'h6D, 8'h61, 8'h63, 8'h68, 8'h20,
      8'h49, 8'h2F, 8'h4F, 8'h20, 8'h49, 8'h44, 8'h3D, 8'h30, 8'h0A
   };

   typedef struct packed {
      logic [1:0]          kind;
      logic [NUM_PINS-1:0] relay;
      logic [NUM_PINS-1:0] stable;
      logic                led;
   } job_type;

   function automatic logic [IDX_W-1:0] reply_len(input logic [1:0] kind);
      logic [IDX_W-1:0] n;
      unique case (kind)
         KIND_IDENT:  n = IDX_W'(ID_LEN);
         KIND_RELAY:  n = IDX_W'(5);
         KIND_STATUS: n = IDX_W'(12);
         default:     n = IDX_W'(1);
      endcase
      return n;
   endfunction

   function automatic logic [7:0] bit_char(input logic b);
      return b ? CHAR_ONE : CHAR_ZERO;
   endfunction

   function automatic logic [7:0] reply_byte(input logic [1:0] kind,
                                             input logic [IDX_W-1:0] idx,
                                             input logic [NUM_PINS-1:0] relay,
                                             input logic [NUM_PINS-1:0] stable);
      logic [7:0] c;
      c = 8'd0;
      unique case (kind)
         KIND_IDENT: begin
            if (idx < IDX_W'(ID_LEN)) c = ID_TEXT[idx];
         end
         KIND_RELAY: begin
            if (idx < IDX_W'(4)) c = bit_char(!stable[idx[1:0]]);
            else                 c = CHAR_LF;
         end
         KIND_STATUS: begin
            case (idx)
               IDX_W'(0):                            c = CHAR_STAR;
               IDX_W'(1), IDX_W'(6):                 c = CHAR_SPACE;
               IDX_W'(2), IDX_W'(3), IDX_W'(4), IDX_W'(5):
                  c = bit_char(relay[2'(idx - IDX_W'(2))]);
               IDX_W'(7), IDX_W'(8), IDX_W'(9), IDX_W'(10):
                  c = bit_char(!stable[2'(idx - IDX_W'(7))]);
               default:                              c = CHAR_LF;
            endcase
         end
         default: c = 8'd0;
      endcase
      return c;
   endfunction

endpackage

// ===== src/lcio_front.sv =====
// Front end: takes transactions, runs the line store, command decode and debounce.
module lcio_front import lcio_pkg::*; #(
   parameter int LINE_BUFFER_SIZE = 256,
   parameter int CHANNELS         = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wen,
   input  logic [7:0]          csr_wdata,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic                in_func,
   input  logic [7:0]          in_byte,
   input  logic [NUM_PINS-1:0] in_pins,
   input  logic                q_full,
   output logic                push,
   output job_type             push_job
);

   localparam int LEN_W = $clog2(LINE_BUFFER_SIZE);

   logic [7:0]          thr_ff;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [7:0]          pfx_ff [PREFIX_DEPTH];
   logic [7:0]          pfx_in [PREFIX_DEPTH];
   logic [NUM_PINS-1:0] relay_ff, relay_in;
   logic [NUM_PINS-1:0] stable_ff, stable_in;
   logic                led_ff, led_in;
   logic [7:0]          cnt_ff [NUM_PINS];
   logic [7:0]          cnt_in [NUM_PINS];
   logic [1:0]          kind;
   logic                take, is_eol, cmd_ve, cmd_sr, cmd_q;
   logic [7:0]          cnt_step;

   assign in_ready = !q_full;
   assign take     = in_valid && in_ready;
   assign is_eol   = (in_byte == CHAR_CR) || (in_byte == CHAR_LF);
   assign cmd_ve   = (pfx_ff[0] == CHAR_V) && (pfx_ff[1] == CHAR_E);
   assign cmd_sr   = (pfx_ff[0] == CHAR_S) && (pfx_ff[1] == CHAR_R) && (pfx_ff[2] == CHAR_SPACE);
   assign cmd_q    = (pfx_ff[0] == CHAR_QUERY);

   // command classification at a line end
   always_comb begin
      kind = KIND_NONE;
      if (len_ff != '0) begin
         if (cmd_ve)      kind = KIND_IDENT;
         else if (cmd_sr) kind = (len_ff >= LEN_W'(PREFIX_DEPTH)) ? KIND_RELAY : KIND_NONE;
         else if (cmd_q)  kind = KIND_STATUS;
      end
   end

   always_comb begin
      len_in    = len_ff;
      pfx_in    = pfx_ff;
      relay_in  = relay_ff;
      stable_in = stable_ff;
      led_in    = led_ff;
      cnt_in    = cnt_ff;
      cnt_step  = 8'd0;
      push_job.kind = KIND_NONE;
      if (take) begin
         if (!in_func) begin
            if (is_eol) begin
               push_job.kind = kind;
               if (kind == KIND_RELAY) begin
                  for (int i = 0; i < NUM_PINS; i++)
                     relay_in[i] = (pfx_ff[3+i] == CHAR_ONE);
               end
               if (kind == KIND_IDENT || kind == KIND_RELAY) led_in = !led_ff;
               for (int i = 0; i < PREFIX_DEPTH; i++) begin
                  if ((LEN_W'(i) < len_ff) ||
                      (kind == KIND_STATUS && LEN_W'(i) == len_ff))
                     pfx_in[i] = 8'd0;
               end
               len_in = '0;
            end else if (len_ff == LEN_W'(LINE_BUFFER_SIZE - 1)) begin
               len_in = '0;   // overflow wrap, store left as is
            end else begin
               if (len_ff < LEN_W'(PREFIX_DEPTH)) pfx_in[len_ff[PFX_IDX_W-1:0]] = in_byte;
               len_in = len_ff + LEN_W'(1);
            end
         end else begin
            for (int i = 0; i < NUM_PINS; i++) begin
               if (i < CHANNELS) begin
                  cnt_step = (cnt_ff[i] == 8'hFF) ? 8'hFF : cnt_ff[i] + 8'd1;
                  if (in_pins[i] == stable_ff[i]) cnt_step = 8'd0;
                  cnt_in[i] = cnt_step;
                  if (cnt_step > thr_ff) stable_in[i] = in_pins[i];
               end
            end
         end
      end
      push_job.relay  = relay_in;
      push_job.stable = stable_in;
      push_job.led    = led_in;
   end

   assign push = take;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THRESHOLD_RESET;
         len_ff    <= '0;
         relay_ff  <= '0;
         stable_ff <= '0;
         led_ff    <= 1'b0;
         for (int i = 0; i < PREFIX_DEPTH; i++) pfx_ff[i] <= 8'd0;
         for (int i = 0; i < NUM_PINS; i++) cnt_ff[i] <= 8'd0;
      end else begin
         if (csr_wen) thr_ff <= csr_wdata;
         len_ff    <= len_in;
         relay_ff  <= relay_in;
         stable_ff <= stable_in;
         led_ff    <= led_in;
         pfx_ff    <= pfx_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== src/lcio_queue.sv =====
// Short job queue between the front end and the reply generator.
module lcio_queue import lcio_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, rptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop)      count_in = count_ff + (QPTR_W+1)'(1);
      else if (!push && pop) count_in = count_ff - (QPTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) wptr_ff <= wptr_ff + QPTR_W'(1);
         if (pop)  rptr_ff <= rptr_ff + QPTR_W'(1);
         count_ff <= count_in;
      end
   end

endmodule

// ===== src/lcio_back.sv =====
// Back end: expands each queued job into its result transactions.
module lcio_back import lcio_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  job_type             head_job,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic                out_has_byte,
   output logic [7:0]          out_byte,
   output logic                out_last,
   output logic [NUM_PINS-1:0] out_relay_drive,
   output logic [NUM_PINS-1:0] out_stable,
   output logic                out_led
);

   logic [IDX_W-1:0]    idx_ff;
   logic                valid_ff;
   logic                has_ff, last_ff, led_ff;
   logic [7:0]          byte_ff;
   logic [NUM_PINS-1:0] drive_ff, stable_ff;
   logic                load, is_last;

   assign load    = head_valid && (!valid_ff || out_ready);
   assign is_last = (idx_ff == reply_len(head_job.kind) - IDX_W'(1));
   assign pop     = load && is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load)           valid_ff <= 1'b1;
         else if (out_ready) valid_ff <= 1'b0;
         if (load) idx_ff <= is_last ? '0 : idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         has_ff    <= (head_job.kind != KIND_NONE);
         byte_ff   <= reply_byte(head_job.kind, idx_ff, head_job.relay, head_job.stable);
         last_ff   <= is_last;
         drive_ff  <= ~head_job.relay;
         stable_ff <= head_job.stable;
         led_ff    <= head_job.led;
      end
   end

   assign out_valid       = valid_ff;
   assign out_has_byte    = has_ff;
   assign out_byte        = byte_ff;
   assign out_last        = last_ff;
   assign out_relay_drive = drive_ff;
   assign out_stable      = stable_ff;
   assign out_led         = led_ff;

endmodule

// ===== src/line_command_io_controller.sv =====
// Top level of the line command I/O controller: front end, job queue, reply generator.
//
// Request channel (req_*): one transaction is either a received serial byte
// (req_tuser = 0) or a millisecond tick with raw pin levels (req_tuser = 1).
// Response channel (rsp_*): every request yields one or more transactions.
// A status-only result has rsp_tuser = 0; reply characters have rsp_tuser = 1.
// rsp_tlast marks the final result of a request. All results of a request
// carry the status (relays, debounced inputs, LED) after that request.
// The csr_* port writes the debounce threshold (reset value 10).
// rsp_tvalid for a request's first result rises once its job has been written into the
// job queue and then loaded into the reply generator's output register.
// Throughput: one result per cycle from the reply generator while rsp_tready is high;
// a request yields 1, 5, 12 or 17 results, so requests flow one per cycle when
// they yield a single result and rsp_tready stays high. The front end keeps
// taking requests while the 4-entry job queue has room, so a stalled response
// side only backs up into req_tready once the queue fills.
// Reset (synchronous, active high) clears the line store, relays, LED,
// debounce state and queue, and restores the threshold.
module line_command_io_controller import lcio_pkg::*; #(
   parameter int LINE_BUFFER_SIZE = 256,
   parameter int CHANNELS         = 4
) (
   input  logic        clock,
   input  logic        reset,
   // config
   input  logic        csr_wen,
   input  logic [7:0]  csr_wdata,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] rx_byte, [11:8] raw_pins, [15:12] zero
   input  logic        req_tuser,   // [0] func
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] tx_byte, [11:8] relay_drive,
                                    // [15:12] stable_levels, [16] led_level, [23:17] zero
   output logic        rsp_tuser,   // [0] has_byte
   output logic        rsp_tlast
);

   job_type             push_job, head_job;
   logic                push, q_full, pop, head_valid;
   logic [7:0]          tx_byte;
   logic [NUM_PINS-1:0] relay_drive, stable_levels;
   logic                led_level;

   lcio_front #(
      .LINE_BUFFER_SIZE(LINE_BUFFER_SIZE),
      .CHANNELS(CHANNELS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_func   (req_tuser),
      .in_byte   (req_tdata[7:0]),
      .in_pins   (req_tdata[11:8]),
      .q_full    (q_full),
      .push      (push),
      .push_job  (push_job)
   );

   // decouples decode from reply emission
   lcio_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   lcio_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_has_byte    (rsp_tuser),
      .out_byte        (tx_byte),
      .out_last        (rsp_tlast),
      .out_relay_drive (relay_drive),
      .out_stable      (stable_levels),
      .out_led         (led_level)
   );

   assign rsp_tdata = {7'd0, led_level, stable_levels, relay_drive, tx_byte};

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the line command I/O controller: command lines, debounce, overflow.
module testbench import lcio_pkg::*; ();

   localparam int LINE_BUFFER_SIZE = 256;
   localparam int RANDOM_ITEMS     = 80;
   localparam int DRAIN_CYCLES     = 8;

   // one response transaction as the block should send it
   typedef struct packed {
      logic                has_byte;
      logic [7:0]          tx_byte;
      logic                last;
      logic [NUM_PINS-1:0] relay_drive;
      logic [NUM_PINS-1:0] stable_levels;
      logic                led_level;
   } reply_beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_wen    = 1'b0;
   logic [7:0]  csr_wdata  = 8'd0;
   logic        req_tvalid = 1'b0;
   logic [15:0] req_tdata  = 16'd0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   // shadow of the block's state
   logic [7:0]          line_store [PREFIX_DEPTH];
   int unsigned         line_len;
   logic [NUM_PINS-1:0] relay_bits;
   logic [NUM_PINS-1:0] stable_bits;
   logic [7:0]          elapsed [NUM_PINS];
   logic                led_bit;
   logic [7:0]          threshold;

   reply_beat_type expected_beats[$];
   int             fail_count = 0;
   int             items_sent = 0;
   bit             no_idle    = 1'b0;

   line_command_io_controller dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // Update the shadow state for one accepted request and queue its replies.
   task automatic predict_replies(input logic is_tick, input logic [7:0] ch,
                                  input logic [NUM_PINS-1:0] pins);
      logic [7:0]          text[$];
      reply_beat_type      beat;
      logic [NUM_PINS-1:0] new_relays;
      int                  n_beats;
      int                  clear_to;
      if (is_tick) begin
         for (int i = 0; i < NUM_PINS; i++) begin
            if (elapsed[i] != 8'hFF) elapsed[i]++;
            if (pins[i] == stable_bits[i]) elapsed[i] = 8'd0;
            if (elapsed[i] > threshold) stable_bits[i] = pins[i];
         end
      end else if (ch == CHAR_CR || ch == CHAR_LF) begin
         if (line_len > 0) begin
            if (line_store[0] == CHAR_V && line_store[1] == CHAR_E) begin
               for (int i = 0; i < ID_LEN; i++) text.push_back(ID_TEXT[i]);
               led_bit = ~led_bit;
            end else if (line_store[0] == CHAR_S && line_store[1] == CHAR_R &&
                         line_store[2] == CHAR_SPACE) begin
               // short relay command is dropped silently
               if (line_len >= PREFIX_DEPTH) begin
                  for (int i = 0; i < NUM_PINS; i++)
                     new_relays[i] = (line_store[3+i] == CHAR_ONE);
                  relay_bits = new_relays;
                  for (int i = 0; i < NUM_PINS; i++)
                     text.push_back(stable_bits[i] ? CHAR_ZERO : CHAR_ONE);
                  text.push_back(CHAR_LF);
                  led_bit = ~led_bit;
               end
            end else if (line_store[0] == CHAR_QUERY) begin
               // the entry just past the line is zeroed too
               if (line_len < PREFIX_DEPTH) line_store[line_len] = 8'd0;
               text.push_back(CHAR_STAR);
               text.push_back(CHAR_SPACE);
               for (int i = 0; i < NUM_PINS; i++)
                  text.push_back(relay_bits[i] ? CHAR_ONE : CHAR_ZERO);
               text.push_back(CHAR_SPACE);
               for (int i = 0; i < NUM_PINS; i++)
                  text.push_back(stable_bits[i] ? CHAR_ZERO : CHAR_ONE);
               text.push_back(CHAR_LF);
            end
         end
         clear_to = (line_len < PREFIX_DEPTH) ? line_len : PREFIX_DEPTH;
         for (int i = 0; i < clear_to; i++) line_store[i] = 8'd0;
         line_len = 0;
      end else if (line_len == LINE_BUFFER_SIZE - 1) begin
         // overflow: byte dropped, count wraps, store keeps old text
         line_len = 0;
      end else begin
         if (line_len < PREFIX_DEPTH) line_store[line_len] = ch;
         line_len++;
      end

      n_beats = (text.size() > 0) ? text.size() : 1;
      for (int k = 0; k < n_beats; k++) begin
         beat.has_byte      = (text.size() > 0);
         beat.tx_byte       = (text.size() > 0) ? text[k] : 8'd0;
         beat.last          = (k == n_beats - 1);
         beat.relay_drive   = ~relay_bits;
         beat.stable_levels = stable_bits;
         beat.led_level     = led_bit;
         expected_beats.push_back(beat);
      end
   endtask

   // Present one request after a random gap and hold it until accepted.
   task automatic send_item(input logic is_tick, input logic [7:0] ch,
                            input logic [NUM_PINS-1:0] pins);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= is_tick;
      req_tdata  <= {4'b0000, pins, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_replies(is_tick, ch, pins);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] ch);
      send_item(1'b0, ch, NUM_PINS'($urandom));
   endtask

   task automatic send_tick(input logic [NUM_PINS-1:0] pins);
      send_item(1'b1, 8'($urandom), pins);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // line character with an occasional tick slipped in ahead of it
   task automatic line_char(input logic [7:0] ch);
      if ($urandom_range(0, 11) == 0) send_tick(NUM_PINS'($urandom));
      send_byte(ch);
   endtask

   function automatic logic [7:0] relay_digit();
      case ($urandom_range(0, 4))
         0, 1:    return CHAR_ONE;
         2, 3:    return CHAR_ZERO;
         default: return 8'($urandom_range(32, 126));
      endcase
   endfunction

   // Stop sending and let every queued reply come out.
   task automatic wait_replies_done();
      int guard;
      req_tvalid <= 1'b0;
      @(posedge clock);
      guard = 0;
      while (expected_beats.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      if (expected_beats.size() != 0) begin
         $display("%0d expected results never arrived", expected_beats.size());
         fail_count++;
         expected_beats.delete();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_threshold(input logic [7:0] value);
      wait_replies_done();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      threshold = value;
   endtask

   // Each command once at the reset threshold, plus field extremes.
   task automatic test_directed_commands();
      send_byte(CHAR_QUERY);
      send_byte(CHAR_CR);
      send_tick(4'hF);
      send_tick(4'h0);
      send_text("VE");
      send_byte(CHAR_LF);
      send_text("SR 1010");
      send_byte(CHAR_CR);
      send_text("SR 1");             // too short, ignored
      send_byte(CHAR_LF);
      send_byte(CHAR_CR);            // empty line
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(CHAR_LF);
   endtask

   // Threshold extremes: immediate change at 0, long hold-off at 254.
   task automatic test_debounce_extremes();
      set_threshold(8'd0);
      send_tick(4'hF);
      send_tick(4'h5);
      send_tick(4'h0);
      send_byte(CHAR_QUERY);
      send_byte(CHAR_LF);
      set_threshold(8'd254);
      repeat (20) send_tick(4'hA);   // well inside the hold-off, levels stay
      send_text("SR 0110");
      send_byte(CHAR_CR);
      repeat (3) send_tick(4'h0);    // glitch, counters restart
      send_tick(4'hA);
      send_byte(CHAR_QUERY);
      send_byte(CHAR_CR);
   endtask

   // Fill the line to the wrap point; old prefix text survives the wrap.
   task automatic test_line_overflow();
      set_threshold(THRESHOLD_RESET);
      send_text("SR 1111");
      repeat (LINE_BUFFER_SIZE - 8) send_byte(8'h78);
      send_byte(8'h5A);              // dropped, length wraps to zero
      send_byte(CHAR_QUERY);
      send_byte(CHAR_CR);
      send_text("SR");
      send_byte(CHAR_LF);
   endtask

   task automatic test_random_traffic();
      int                  start;
      int                  kind;
      int                  run_len;
      logic [NUM_PINS-1:0] pins;
      start = items_sent;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       set_threshold(8'd0);
            1:       set_threshold(8'd3);
            2:       set_threshold(8'($urandom_range(1, 20)));
            default: set_threshold(THRESHOLD_RESET);
         endcase
         while (items_sent < start + (phase + 1) * RANDOM_ITEMS / 4) begin
            no_idle = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 9);
            case (kind)
               0, 1: begin
                  line_char(CHAR_V);
                  line_char(CHAR_E);
                  repeat ($urandom_range(0, 3)) line_char(8'($urandom_range(32, 126)));
               end
               2, 3, 4: begin
                  line_char(CHAR_S);
                  line_char(CHAR_R);
                  line_char(CHAR_SPACE);
                  repeat (4) line_char(relay_digit());
                  repeat ($urandom_range(0, 2)) line_char(8'($urandom_range(32, 126)));
               end
               5: begin
                  // near misses of the relay command
                  line_char(CHAR_S);
                  line_char($urandom_range(0, 1) ? CHAR_R : CHAR_E);
                  line_char($urandom_range(0, 1) ? CHAR_SPACE : CHAR_ONE);
                  repeat ($urandom_range(0, 5)) line_char(relay_digit());
               end
               6: begin
                  line_char(CHAR_QUERY);
                  repeat ($urandom_range(0, 9)) line_char(8'($urandom_range(32, 126)));
               end
               7: begin
                  pins = NUM_PINS'($urandom);
                  run_len = $urandom_range(1, 14);
                  repeat (run_len) begin
                     if ($urandom_range(0, 9) == 0)
                        send_tick(pins ^ NUM_PINS'(1 << $urandom_range(0, NUM_PINS - 1)));
                     else
                        send_tick(pins);
                  end
               end
               8: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
               default: if ($urandom_range(0, 1)) line_char(CHAR_V);
            endcase
            if (kind < 7 || kind == 9) begin
               case ($urandom_range(0, 9))
                  0:       ;                     // no terminator, line runs on
                  1: begin
                     send_byte(CHAR_CR);
                     send_byte(CHAR_LF);
                  end
                  default: send_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
               endcase
            end
         end
      end
      no_idle = 1'b0;
   endtask

   // Response side: random stall per transaction, then compare.
   initial begin : reply_checker
      int             stall;
      reply_beat_type want;
      do @(posedge clock); while (reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 12);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         if (expected_beats.size() == 0) begin
            if (fail_count < 10)
               $display("unexpected result: tuser=%0d tdata=%h tlast=%0d",
                        rsp_tuser, rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_tuser !== want.has_byte || rsp_tdata[7:0] !== want.tx_byte ||
                rsp_tlast !== want.last || rsp_tdata[11:8] !== want.relay_drive ||
                rsp_tdata[15:12] !== want.stable_levels ||
                rsp_tdata[16] !== want.led_level || rsp_tdata[23:17] !== 7'd0) begin
               if (fail_count < 10)
                  $display({"mismatch: want has=%0d tx=%h last=%0d relay=%h stable=%h",
                            " led=%0d; got has=%0d tx=%h last=%0d relay=%h stable=%h",
                            " led=%0d pad=%h"},
                           want.has_byte, want.tx_byte, want.last, want.relay_drive,
                           want.stable_levels, want.led_level, rsp_tuser, rsp_tdata[7:0],
                           rsp_tlast, rsp_tdata[11:8], rsp_tdata[15:12], rsp_tdata[16],
                           rsp_tdata[23:17]);
               fail_count++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < PREFIX_DEPTH; i++) line_store[i] = 8'd0;
      for (int i = 0; i < NUM_PINS; i++) elapsed[i] = 8'd0;
      line_len    = 0;
      relay_bits  = '0;
      stable_bits = '0;
      led_bit     = 1'b0;
      threshold   = THRESHOLD_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed_commands();
      test_debounce_extremes();
      test_line_overflow();
      test_random_traffic();

      wait_replies_done();
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #5000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== line_command_io_controller.f =====
src/lcio_pkg.sv
src/lcio_front.sv
src/lcio_queue.sv
src/lcio_back.sv
src/line_command_io_controller.sv
test/testbench.sv
